[hw/rtl/rbap_pkg.sv]
// Shared types and constants for the RESP bulk array request parser.
// No dependencies; imported by rbap_parse_core and resp_bulk_array_parser.
package rbap_pkg;

    // Byte values of the protocol markers.
    localparam logic [7:0] CHAR_ARRAY  = 8'h2A;  // '*'
    localparam logic [7:0] CHAR_BULK   = 8'h24;  // '$'
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Configuration register map.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ARGUMENTS       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ARGUMENT_LENGTH = 1'b1;

    // Field widths fixed by the result format and the register file.
    localparam int unsigned ARG_CNT_W = 5;   // argument count and its limit
    localparam int unsigned ARG_IDX_W = 4;   // argument index
    localparam int unsigned LIMIT_W   = 16;  // length limit register
    localparam int unsigned ACC_W     = 16;  // decimal accumulator
    localparam int unsigned PROD_W    = 20;  // accumulator * 10 + digit
    localparam int unsigned IDX_RANGE = 16;  // arguments addressable by arg_index

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COUNT,
        PH_COUNT_LF,
        PH_DOLLAR,
        PH_LEN,
        PH_LEN_LF,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD   = 2'd0,
        EV_ARG_END   = 2'd1,
        EV_EMPTY_REQ = 2'd2,
        EV_FORMAT_ERR = 2'd3
    } event_t;

    // One parsed result as produced by the core.
    typedef struct packed {
        logic                 valid;
        event_t               event_res;
        logic [7:0]           data_byte;
        logic [ARG_IDX_W-1:0] arg_index;
        logic                 request_done;
    } rbap_result_t;

endpackage

[hw/rtl/resp_bulk_array_parser.sv]
// Top level of the RESP bulk array request parser: input and result registers,
// configuration registers and checks. Depends on rbap_pkg and rbap_parse_core.
//
// Usage:
//   Request bytes enter on the s_ channel, one transaction per byte. Each byte
//   gives zero or one result transaction on the m_ channel: a payload byte with
//   its argument index, an argument end (request_done set on the last one), an
//   empty request event, or a format error, after which the parser waits for
//   the next '*'.
//   Limits are written on the cfg_ channel (index 0: max arguments, index 1:
//   max argument length). The user must write them only while no request is
//   in flight; the block does not enforce this. An accepted byte waits in the
//   input register, then the parse logic loads its result into the result
//   register; a single state update plus one multiply-by-ten accumulate lie
//   between them. Throughput: one byte per cycle while m_ready is high.
//   Stall: when a result waits and m_ready is low, the result register holds
//   and the input register takes one more byte, after which s_ready drops.
//   Reset: synchronous, active low; both registers empty, the parser idle and
//   the limits back to 16 arguments and 65535 bytes.
module resp_bulk_array_parser
    import rbap_pkg::*;
#(
    parameter int unsigned MAX_ARGS  = 16,
    parameter int unsigned LEN_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Request byte stream.
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    // Parse results.
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_event_res,
    output logic [7:0]             m_data_byte,
    output logic [ARG_IDX_W-1:0]   m_arg_index,
    output logic                   m_request_done,
    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    rbap_result_t         out_reg;
    logic [ARG_CNT_W-1:0] max_arguments_reg;
    logic [LIMIT_W-1:0]   max_argument_length_reg;
    logic                 advance;
    logic                 step;
    rbap_result_t         core_result;

    // The result register can load when empty or being drained.
    assign advance   = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_arguments_reg       <= ARG_CNT_W'(16);
            max_argument_length_reg <= {LIMIT_W{1'b1}};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAX_ARGUMENTS:       max_arguments_reg <= cfg_data[ARG_CNT_W-1:0];
                CFG_MAX_ARGUMENT_LENGTH: max_argument_length_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register holds one accepted byte until the parser consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    rbap_parse_core #(
        .MAX_ARGS  (MAX_ARGS),
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .step                (step),
        .rx_byte             (in_byte_reg),
        .max_arguments       (max_arguments_reg),
        .max_argument_length (max_argument_length_reg),
        .result              (core_result)
    );

    // Result register; a consumed byte with no result leaves it empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && core_result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = out_reg.event_res;
    assign m_data_byte    = out_reg.data_byte;
    assign m_arg_index    = out_reg.arg_index;
    assign m_request_done = out_reg.request_done;

    // A held input byte must survive until the parser takes it.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte lost before it was parsed");

    // Only payload results carry a data byte.
    a_data_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res != EV_PAYLOAD) |-> (m_data_byte == 8'd0))
        else $error("non-payload result carries data");

    // Request completion is flagged only on an argument end.
    a_done_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_request_done |-> (m_event_res == EV_ARG_END))
        else $error("request_done set on a result other than an argument end");

endmodule

[hw/rtl/rbap_parse_core.sv]
// Parser state machine: phase, argument and byte counters, decimal accumulator.
// Depends on rbap_pkg; consumes one byte per step and returns at most one result.
module rbap_parse_core
    import rbap_pkg::*;
#(
    parameter int unsigned MAX_ARGS  = 16,
    parameter int unsigned LEN_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  logic [ARG_CNT_W-1:0] max_arguments,
    input  logic [LIMIT_W-1:0]   max_argument_length,
    output rbap_result_t         result
);

    // Static clamps of the configured limits.
    localparam int unsigned CNT_CAP = (MAX_ARGS < IDX_RANGE) ? MAX_ARGS : IDX_RANGE;
    localparam int unsigned LEN_CAP = (LEN_WIDTH >= LIMIT_W) ?
                                      ((1 << LIMIT_W) - 1) : ((1 << LEN_WIDTH) - 1);

    phase_t                 phase_reg, phase_next;
    logic [ARG_CNT_W-1:0]   args_remaining_reg, args_remaining_next;
    logic [ARG_IDX_W-1:0]   current_arg_reg, current_arg_next;
    logic [LEN_WIDTH-1:0]   bytes_remaining_reg, bytes_remaining_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   digit_seen_reg, digit_seen_next;

    logic [ARG_CNT_W-1:0]   count_limit;
    logic [LIMIT_W-1:0]     length_limit;
    logic [PROD_W-1:0]      number_limit;
    logic [PROD_W-1:0]      acc_wide;
    logic [PROD_W-1:0]      acc_product;
    logic                   is_digit;
    logic                   is_cr;
    logic [LEN_WIDTH-1:0]   bytes_dec;

    // Effective limits after clamping to the build-time caps.
    always_comb begin
        if (max_arguments > ARG_CNT_W'(CNT_CAP)) begin
            count_limit = ARG_CNT_W'(CNT_CAP);
        end else begin
            count_limit = max_arguments;
        end
        if (max_argument_length > LIMIT_W'(LEN_CAP)) begin
            length_limit = LIMIT_W'(LEN_CAP);
        end else begin
            length_limit = max_argument_length;
        end
    end

    // One decimal digit step: acc * 10 + digit, done as shift and add.
    assign is_digit    = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_cr       = (rx_byte == CHAR_CR);
    assign acc_wide    = PROD_W'(acc_reg);
    assign acc_product = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(rx_byte - CHAR_ZERO);
    assign number_limit = (phase_reg == PH_COUNT) ? PROD_W'(count_limit)
                                                  : PROD_W'(length_limit);
    assign bytes_dec   = bytes_remaining_reg - LEN_WIDTH'(1);

    // Next state and result for the byte being consumed.
    always_comb begin
        phase_next           = phase_reg;
        args_remaining_next  = args_remaining_reg;
        current_arg_next     = current_arg_reg;
        bytes_remaining_next = bytes_remaining_reg;
        acc_next             = acc_reg;
        digit_seen_next      = digit_seen_reg;
        result               = '{valid: 1'b0, event_res: EV_PAYLOAD, data_byte: 8'd0,
                                 arg_index: '0, request_done: 1'b0};

        case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == CHAR_ARRAY) begin
                    phase_next      = PH_COUNT;
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                end
            end
            PH_COUNT, PH_LEN: begin
                if (is_cr && digit_seen_reg) begin
                    phase_next = (phase_reg == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
                end else if (is_digit && (acc_product <= number_limit)) begin
                    acc_next        = acc_product[ACC_W-1:0];
                    digit_seen_next = 1'b1;
                end else begin
                    result.valid     = 1'b1;
                    result.event_res = EV_FORMAT_ERR;
                end
            end
            PH_COUNT_LF: begin
                if (rx_byte != CHAR_LF) begin
                    result.valid     = 1'b1;
                    result.event_res = EV_FORMAT_ERR;
                end else if (acc_reg == '0) begin
                    phase_next       = PH_IDLE;
                    result.valid     = 1'b1;
                    result.event_res = EV_EMPTY_REQ;
                end else begin
                    args_remaining_next = acc_reg[ARG_CNT_W-1:0];
                    current_arg_next    = '0;
                    phase_next          = PH_DOLLAR;
                end
            end
            PH_DOLLAR: begin
                if (rx_byte != CHAR_BULK) begin
                    result.valid     = 1'b1;
                    result.event_res = EV_FORMAT_ERR;
                end else begin
                    phase_next      = PH_LEN;
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                end
            end
            PH_LEN_LF: begin
                if (rx_byte != CHAR_LF) begin
                    result.valid     = 1'b1;
                    result.event_res = EV_FORMAT_ERR;
                end else if (acc_reg == '0) begin
                    phase_next           = PH_TRAILER;
                    bytes_remaining_next = LEN_WIDTH'(2);
                end else begin
                    phase_next           = PH_PAYLOAD;
                    bytes_remaining_next = LEN_WIDTH'(acc_reg);
                end
            end
            PH_PAYLOAD: begin
                if (bytes_dec == '0) begin
                    phase_next           = PH_TRAILER;
                    bytes_remaining_next = LEN_WIDTH'(2);
                end else begin
                    bytes_remaining_next = bytes_dec;
                end
                result.valid     = 1'b1;
                result.event_res = EV_PAYLOAD;
                result.data_byte = rx_byte;
                result.arg_index = current_arg_reg;
            end
            PH_TRAILER: begin
                if (bytes_remaining_reg > LEN_WIDTH'(1)) begin
                    bytes_remaining_next = bytes_dec;
                end else begin
                    bytes_remaining_next = '0;
                    current_arg_next     = current_arg_reg + ARG_IDX_W'(1);
                    result.valid         = 1'b1;
                    result.event_res     = EV_ARG_END;
                    result.arg_index     = current_arg_reg;
                    if (args_remaining_reg <= ARG_CNT_W'(1)) begin
                        args_remaining_next = '0;
                        phase_next          = PH_IDLE;
                        result.request_done = 1'b1;
                    end else begin
                        args_remaining_next = args_remaining_reg - ARG_CNT_W'(1);
                        phase_next          = PH_DOLLAR;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // A format error drops the request and waits for the next array marker.
        if (result.valid && (result.event_res == EV_FORMAT_ERR)) begin
            phase_next      = PH_IDLE;
            acc_next        = '0;
            digit_seen_next = 1'b0;
        end
    end

    // Parser state registers advance only when a byte is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            args_remaining_reg  <= '0;
            current_arg_reg     <= '0;
            bytes_remaining_reg <= '0;
            acc_reg             <= '0;
            digit_seen_reg      <= 1'b0;
        end else if (step) begin
            phase_reg           <= phase_next;
            args_remaining_reg  <= args_remaining_next;
            current_arg_reg     <= current_arg_next;
            bytes_remaining_reg <= bytes_remaining_next;
            acc_reg             <= acc_next;
            digit_seen_reg      <= digit_seen_next;
        end
    end

endmodule

[verif/resp_bulk_array_parser_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for resp_bulk_array_parser: a byte-level model of the request
// parser predicts every result transaction, and a scoreboard class checks each one.
// Depends on rbap_pkg and the resp_bulk_array_parser RTL.
module resp_bulk_array_parser_tb;
    import rbap_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int IDLE_PERCENT    = 23;
    localparam int SETTLE_CYCLES   = 8;     // two-stage pipeline plus margin
    localparam int STALL_LIMIT     = 4000;  // well above the longest receiver hold-off
    localparam int HOLD_CYCLES     = 250;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int NUM_PHASES      = 7;
    localparam logic [7:0] FILL_BYTE = 8'h78;
    localparam string CR   = "\015";
    localparam string CRLF = "\015\012";

    // Limit settings per phase: reset values, zero, one, over the clamp, and a few others.
    localparam int PHASE_ARGS [NUM_PHASES] = '{16, 0, 1, 31, 5, 16, 16};
    localparam int PHASE_LENS [NUM_PHASES] = '{65535, 0, 1, 65535, 20, 43690, 300};

    typedef struct {
        event_t               ev;
        logic [7:0]           data;
        logic [ARG_IDX_W-1:0] arg;
        logic                 done;
    } parse_event_t;

    // Byte-level model of the parser plus the queue of results it still owes.
    class request_scoreboard;
        phase_t               phase;
        logic [4:0]           args_left;
        logic [ARG_IDX_W-1:0] cur_arg;
        int unsigned          bytes_left;
        int unsigned          number;
        bit                   digit_seen;
        logic [4:0]           max_args;
        logic [15:0]          max_len;
        parse_event_t         expected_q[$];
        int                   errors;

        function new();
            phase      = PH_IDLE;
            args_left  = '0;
            cur_arg    = '0;
            bytes_left = 0;
            number     = 0;
            digit_seen = 1'b0;
            max_args   = 5'd16;
            max_len    = 16'hFFFF;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_MAX_ARGUMENTS) begin
                max_args = value[4:0];
            end else begin
                max_len = value;
            end
        endfunction

        // The count limit is also clamped to the range of arg_index (equal to MAX_ARGS here).
        function int unsigned count_limit();
            return (max_args > IDX_RANGE) ? IDX_RANGE : max_args;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void expect_event(event_t ev, logic [7:0] data, logic [ARG_IDX_W-1:0] arg,
                                   logic done);
            parse_event_t item;
            item.ev   = ev;
            item.data = data;
            item.arg  = arg;
            item.done = done;
            expected_q.insert(expected_q.size(), item);
        endfunction

        function void format_error();
            phase      = PH_IDLE;
            number     = 0;
            digit_seen = 1'b0;
            expect_event(EV_FORMAT_ERR, 8'h00, '0, 1'b0);
        endfunction

        // Returns 0 when the byte makes the decimal number invalid.
        function bit accept_digit(logic [7:0] value, int unsigned limit, phase_t lf_phase);
            if (value == CHAR_CR) begin
                if (!digit_seen) return 1'b0;
                phase = lf_phase;
                return 1'b1;
            end
            if (value < CHAR_ZERO || value > CHAR_NINE) return 1'b0;
            number     = number * 10 + (value - CHAR_ZERO);
            digit_seen = 1'b1;
            return number <= limit;
        endfunction

        // Advances the model by one accepted byte. Returns 0 for a byte dropped while idle.
        function bit note_byte(logic [7:0] value);
            bit last;
            case (phase)
                PH_IDLE: begin
                    if (value != CHAR_ARRAY) return 1'b0;
                    phase      = PH_COUNT;
                    number     = 0;
                    digit_seen = 1'b0;
                end
                PH_COUNT: begin
                    if (!accept_digit(value, count_limit(), PH_COUNT_LF)) format_error();
                end
                PH_COUNT_LF: begin
                    if (value != CHAR_LF) begin
                        format_error();
                    end else if (number == 0) begin
                        phase = PH_IDLE;
                        expect_event(EV_EMPTY_REQ, 8'h00, '0, 1'b0);
                    end else begin
                        args_left = number[4:0];
                        cur_arg   = '0;
                        phase     = PH_DOLLAR;
                    end
                end
                PH_DOLLAR: begin
                    if (value != CHAR_BULK) begin
                        format_error();
                    end else begin
                        phase      = PH_LEN;
                        number     = 0;
                        digit_seen = 1'b0;
                    end
                end
                PH_LEN: begin
                    if (!accept_digit(value, max_len, PH_LEN_LF)) format_error();
                end
                PH_LEN_LF: begin
                    if (value != CHAR_LF) begin
                        format_error();
                    end else if (number == 0) begin
                        phase      = PH_TRAILER;
                        bytes_left = 2;
                    end else begin
                        phase      = PH_PAYLOAD;
                        bytes_left = number;
                    end
                end
                PH_PAYLOAD: begin
                    bytes_left--;
                    if (bytes_left == 0) begin
                        phase      = PH_TRAILER;
                        bytes_left = 2;
                    end
                    expect_event(EV_PAYLOAD, value, cur_arg, 1'b0);
                end
                default: begin
                    // Trailer bytes are skipped unchecked; the second one ends the argument.
                    if (bytes_left > 1) begin
                        bytes_left--;
                    end else begin
                        bytes_left = 0;
                        last       = (args_left <= 1);
                        expect_event(EV_ARG_END, 8'h00, cur_arg, last);
                        args_left  = last ? 5'd0 : args_left - 5'd1;
                        cur_arg    = cur_arg + 1'b1;
                        phase      = last ? PH_IDLE : PH_DOLLAR;
                    end
                end
            endcase
            return 1'b1;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(event_t ev, logic [7:0] data, logic [ARG_IDX_W-1:0] arg,
                          logic done);
            parse_event_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result event %0d data %02h arg %0d done %0d",
                                          ev, data, arg, done));
                return;
            end
            want = expected_q.pop_front();
            if (ev !== want.ev)
                report_mismatch($sformatf("event_res %0d, expected %0d", ev, want.ev));
            if (data !== want.data)
                report_mismatch($sformatf("data_byte %02h, expected %02h", data, want.data));
            if (arg !== want.arg)
                report_mismatch($sformatf("arg_index %0d, expected %0d", arg, want.arg));
            if (done !== want.done)
                report_mismatch($sformatf("request_done %0d, expected %0d", done, want.done));
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_rx_byte = 8'h00;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [1:0]             m_event_res;
    logic [7:0]             m_data_byte;
    logic [ARG_IDX_W-1:0]   m_arg_index;
    logic                   m_request_done;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    request_scoreboard sb;
    int                hold_left      = 0;
    bit                no_gaps        = 1'b0;
    int                accepted_bytes = 0;
    int                stall_cycles   = 0;
    logic [7:0]        req_bytes[$];

    resp_bulk_array_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_data_byte    (m_data_byte),
        .m_arg_index    (m_arg_index),
        .m_request_done (m_request_done),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // Result side: random back-pressure, a long hold-off on request, none in quiet phases.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (no_gaps) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Every result transaction is scored against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(event_t'(m_event_res), m_data_byte, m_arg_index, m_request_done);
    end

    // Count cycles in which no transaction moves on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_byte(value)) accepted_bytes++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    task automatic send_queued();
        foreach (req_bytes[i]) send_byte(req_bytes[i]);
    endtask

    // Add one byte to the end of the request being built.
    function automatic void append_byte(logic [7:0] value);
        req_bytes.insert(req_bytes.size(), value);
    endfunction

    function automatic void append_text(string txt);
        for (int i = 0; i < txt.len(); i++) append_byte(txt[i]);
    endfunction

    // Decimal text, now and then with a leading zero.
    function automatic void append_number(int unsigned value);
        string txt;
        txt = $sformatf("%0d", value);
        if ($urandom_range(0, 9) == 0) txt = {"0", txt};
        append_text(txt);
    endfunction

    // Feed filler until the parser is idle again: it errors out or completes the request.
    task automatic park_parser();
        while (sb.phase != PH_IDLE) send_byte(FILL_BYTE);
    endtask

    // Stop sending, wait for every predicted result, then let the pipeline settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    // One random request: mostly well formed, some corrupted or cut short, some plain noise.
    task automatic random_request();
        int unsigned lim;
        int unsigned nargs;
        int unsigned len;
        int unsigned len_cap;
        int unsigned pos;
        int unsigned shape;
        int unsigned pick;
        bit          over;
        req_bytes.delete();
        lim   = sb.count_limit();
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            repeat ($urandom_range(1, 6)) begin
                append_byte(($urandom_range(0, 3) == 0) ? CHAR_ARRAY
                                                        : 8'($urandom_range(0, 255)));
            end
        end else begin
            over = ($urandom_range(0, 19) == 0);
            if (over)
                nargs = lim + 1 + $urandom_range(0, 20);
            else if ($urandom_range(0, 9) == 0)
                nargs = $urandom_range(0, lim);
            else
                nargs = $urandom_range(0, (lim < 3) ? lim : 3);
            append_byte(CHAR_ARRAY);
            append_number(nargs);
            append_text(CRLF);
            if (!over) begin
                len_cap = (sb.max_len < 12) ? sb.max_len : 12;
                for (int a = 0; a < nargs; a++) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        len = sb.max_len + 1;
                    else if (pick == 1 && sb.max_len <= 300)
                        len = sb.max_len;
                    else
                        len = $urandom_range(0, len_cap);
                    append_byte(CHAR_BULK);
                    append_number(len);
                    // An oversized length errors on its last digit; nothing after it matters.
                    if (len > sb.max_len) break;
                    append_text(CRLF);
                    repeat (len) append_byte(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 4) == 0) begin
                        append_byte(8'($urandom_range(0, 255)));
                        append_byte(8'($urandom_range(0, 255)));
                    end else begin
                        append_text(CRLF);
                    end
                end
            end
            // Break some requests: overwrite one byte and sometimes drop the rest.
            if (shape < 25) begin
                pos = $urandom_range(0, req_bytes.size() - 1);
                req_bytes[pos] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0) req_bytes = req_bytes[0:pos];
            end
        end
        send_queued();
    endtask

    initial begin
        int phase_start;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed cases with the reset limits.
        send_text({"*0", CRLF});
        send_text({"*2", CRLF, "$0", CRLF, CRLF, "$3", CRLF});
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_ARRAY);
        send_byte(CHAR_CR);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text({"x$", CRLF});
        send_text("*-1");
        send_text({"*", CR});
        send_text({"*1", CR, "X"});
        send_text({"*1", CRLF, "#"});
        send_text("*17");
        send_text({"*1", CRLF, "$65536"});
        send_text({"*1", CRLF, "*1", CRLF});
        send_text({"*1", CRLF, "$+"});
        send_text({"*1", CRLF, "$", CR});
        send_text({"*1", CRLF, "$2", CR, "Z"});
        send_text({"*016", CRLF});
        repeat (16) send_text({"$0", CRLF, CRLF});

        // Hold the result side off while a long argument streams in, then pause the sender.
        hold_left = HOLD_CYCLES;
        req_bytes.delete();
        append_text({"*1", CRLF, "$80", CRLF});
        repeat (80) append_byte(8'($urandom_range(0, 255)));
        append_text(CRLF);
        send_queued();
        drain_results();

        // Random phases, each under its own limit settings.
        for (int p = 0; p < NUM_PHASES; p++) begin
            park_parser();
            drain_results();
            write_reg(CFG_MAX_ARGUMENTS, CFG_DATA_W'(PHASE_ARGS[p]));
            write_reg(CFG_MAX_ARGUMENT_LENGTH, CFG_DATA_W'(PHASE_LENS[p]));
            no_gaps     = (p == 3);
            phase_start = accepted_bytes;
            while (accepted_bytes - phase_start < ITEMS_PER_PHASE) random_request();
        end
        no_gaps = 1'b0;

        drain_results();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/rbap_pkg.sv
hw/rtl/rbap_parse_core.sv
hw/rtl/resp_bulk_array_parser.sv
verif/resp_bulk_array_parser_tb.sv
